// File: hdl/icr_pkg.sv
package icr_pkg;

  localparam int QDepth   = 8;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = QPtrW + 1;
  localparam int DivSteps = 25;
  localparam int DeltaW   = 37;

  localparam logic [15:0] CoefOne = 16'h8000;
  localparam logic [24:0] WOne    = 25'h100_0000;

  typedef struct packed {
    logic signed [31:0] ref_vel_x;
    logic signed [31:0] ref_vel_y;
    logic signed [31:0] oth_vel_x;
    logic signed [31:0] oth_vel_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [31:0]        ref_mass;
    logic [31:0]        oth_mass;
    logic [48:0]        sep_mag;
    logic [16:0]        f15;
    logic               applied;
    logic               sat;
  } icr_item_t;

  typedef struct packed {
    logic signed [31:0] ref_new_vel_x;
    logic signed [31:0] ref_new_vel_y;
    logic signed [31:0] oth_new_vel_x;
    logic signed [31:0] oth_new_vel_y;
    logic               impulse_applied;
    logic               saturated;
  } icr_res_t;

endpackage

// File: hdl/impulse_collision_response.sv
// channel  | handshake            | words
// ---------+----------------------+------------------------------------------
// input    | push, full           | velocities, normal, masses, coefficients
// result   | pop, empty           | new velocities, impulse_applied, saturated
//
// One contact per cycle sustained while full stays low and results are popped;
// the mass share comes from the 25-step divider in the back pipeline.
// Reset clears all queues and valid flags; no clearing pass is needed.
// The front never stalls; full rises while six or more words wait between front and back.
// The back pipeline halts as a whole while the two-word result buffer is full.
module impulse_collision_response (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] ref_vel_x_i,
  input  logic signed [31:0] ref_vel_y_i,
  input  logic signed [31:0] oth_vel_x_i,
  input  logic signed [31:0] oth_vel_y_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic [31:0]        ref_mass_i,
  input  logic [31:0]        oth_mass_i,
  input  logic [15:0]        ref_hardness_i,
  input  logic [15:0]        ref_elasticity_i,
  input  logic [15:0]        oth_hardness_i,
  input  logic [15:0]        oth_elasticity_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] ref_new_vel_x_o,
  output logic signed [31:0] ref_new_vel_y_o,
  output logic signed [31:0] oth_new_vel_x_o,
  output logic signed [31:0] oth_new_vel_y_o,
  output logic               impulse_applied_o,
  output logic               saturated_o
);

  logic               in_vld;
  logic               item_vld;
  icr_pkg::icr_item_t item, q_item;
  logic               q_empty, q_pop;
  icr_pkg::icr_res_t  res;

  assign in_vld = push && !full;

  icr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_vld_i         (in_vld),
    .ref_vel_x_i      (ref_vel_x_i),
    .ref_vel_y_i      (ref_vel_y_i),
    .oth_vel_x_i      (oth_vel_x_i),
    .oth_vel_y_i      (oth_vel_y_i),
    .normal_x_i       (normal_x_i),
    .normal_y_i       (normal_y_i),
    .ref_mass_i       (ref_mass_i),
    .oth_mass_i       (oth_mass_i),
    .ref_hardness_i   (ref_hardness_i),
    .ref_elasticity_i (ref_elasticity_i),
    .oth_hardness_i   (oth_hardness_i),
    .oth_elasticity_i (oth_elasticity_i),
    .item_vld_o       (item_vld),
    .item_o           (item)
  );

  icr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (item_vld),
    .wr_item_i (item),
    .rd_i      (q_pop),
    .rd_item_o (q_item),
    .empty_o   (q_empty),
    .full_o    (full)
  );

  icr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign ref_new_vel_x_o   = res.ref_new_vel_x;
  assign ref_new_vel_y_o   = res.ref_new_vel_y;
  assign oth_new_vel_x_o   = res.oth_new_vel_x;
  assign oth_new_vel_y_o   = res.oth_new_vel_y;
  assign impulse_applied_o = res.impulse_applied;
  assign saturated_o       = res.saturated;

endmodule

// File: hdl/icr_front.sv
module icr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_vld_i,
  input  logic signed [31:0]    ref_vel_x_i,
  input  logic signed [31:0]    ref_vel_y_i,
  input  logic signed [31:0]    oth_vel_x_i,
  input  logic signed [31:0]    oth_vel_y_i,
  input  logic signed [15:0]    normal_x_i,
  input  logic signed [15:0]    normal_y_i,
  input  logic [31:0]           ref_mass_i,
  input  logic [31:0]           oth_mass_i,
  input  logic [15:0]           ref_hardness_i,
  input  logic [15:0]           ref_elasticity_i,
  input  logic [15:0]           oth_hardness_i,
  input  logic [15:0]           oth_elasticity_i,
  output logic                  item_vld_o,
  output icr_pkg::icr_item_t    item_o
);

  function automatic logic [15:0] clamp_coef(input logic [15:0] v);
    clamp_coef = (v > icr_pkg::CoefOne) ? icr_pkg::CoefOne : v;
  endfunction

  logic signed [32:0] rvx_d, rvy_d;
  logic signed [48:0] px_d, py_d;

  logic               f1_vld_q;
  logic signed [48:0] f1_px_q, f1_py_q;
  logic signed [31:0] f1_rvx_q, f1_rvy_q, f1_ovx_q, f1_ovy_q;
  logic signed [15:0] f1_nx_q, f1_ny_q;
  logic [31:0]        f1_mr_q, f1_mo_q;
  logic [15:0]        f1_hr_q, f1_er_q, f1_ho_q, f1_eo_q;

  logic signed [49:0] sep;
  logic               sep_pos, applied, clamp_any;
  logic [15:0]        hr, er, ho, eo;
  logic [31:0]        rest;
  logic [32:0]        f15_sum;

  logic               item_vld_q;
  icr_pkg::icr_item_t item_d, item_q;

  assign rvx_d = 33'(ref_vel_x_i) - 33'(oth_vel_x_i);
  assign rvy_d = 33'(ref_vel_y_i) - 33'(oth_vel_y_i);
  assign px_d  = 49'(rvx_d) * 49'(normal_x_i);
  assign py_d  = 49'(rvy_d) * 49'(normal_y_i);

  always_ff @(posedge clk_i) begin
    if (in_vld_i) begin
      f1_px_q  <= px_d;
      f1_py_q  <= py_d;
      f1_rvx_q <= ref_vel_x_i;
      f1_rvy_q <= ref_vel_y_i;
      f1_ovx_q <= oth_vel_x_i;
      f1_ovy_q <= oth_vel_y_i;
      f1_nx_q  <= normal_x_i;
      f1_ny_q  <= normal_y_i;
      f1_mr_q  <= ref_mass_i;
      f1_mo_q  <= oth_mass_i;
      f1_hr_q  <= ref_hardness_i;
      f1_er_q  <= ref_elasticity_i;
      f1_ho_q  <= oth_hardness_i;
      f1_eo_q  <= oth_elasticity_i;
    end
  end

  always_comb begin
    sep       = 50'(f1_px_q) + 50'(f1_py_q);
    sep_pos   = !sep[49] && (sep != '0);
    applied   = ((f1_nx_q != '0) || (f1_ny_q != '0)) && !sep_pos &&
                ((f1_mr_q != '0) || (f1_mo_q != '0));
    hr        = clamp_coef(f1_hr_q);
    er        = clamp_coef(f1_er_q);
    ho        = clamp_coef(f1_ho_q);
    eo        = clamp_coef(f1_eo_q);
    clamp_any = (f1_hr_q > icr_pkg::CoefOne) || (f1_er_q > icr_pkg::CoefOne) ||
                (f1_ho_q > icr_pkg::CoefOne) || (f1_eo_q > icr_pkg::CoefOne);
    rest      = (32'(hr) * 32'(eo)) + (32'(er) * 32'(ho));
    f15_sum   = 33'(rest) + 33'h4000_4000;

    item_d.ref_vel_x = f1_rvx_q;
    item_d.ref_vel_y = f1_rvy_q;
    item_d.oth_vel_x = f1_ovx_q;
    item_d.oth_vel_y = f1_ovy_q;
    item_d.normal_x  = f1_nx_q;
    item_d.normal_y  = f1_ny_q;
    item_d.ref_mass  = f1_mr_q;
    item_d.oth_mass  = f1_mo_q;
    item_d.sep_mag   = 49'(-sep);
    item_d.f15       = f15_sum[31:15];
    item_d.applied   = applied;
    item_d.sat       = applied && clamp_any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q   <= 1'b0;
      item_vld_q <= 1'b0;
    end else begin
      f1_vld_q   <= in_vld_i;
      item_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f1_vld_q) begin
      item_q <= item_d;
    end
  end

  assign item_vld_o = item_vld_q;
  assign item_o     = item_q;

endmodule

// File: hdl/icr_queue.sv
module icr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  icr_pkg::icr_item_t wr_item_i,
  input  logic               rd_i,
  output icr_pkg::icr_item_t rd_item_o,
  output logic               empty_o,
  output logic               full_o
);

  icr_pkg::icr_item_t              mem_q [icr_pkg::QDepth];
  logic [icr_pkg::QPtrW-1:0]       wptr_q, rptr_q;
  logic [icr_pkg::QCntW-1:0]       cnt_q;
  logic                            do_rd;

  assign empty_o   = (cnt_q == '0);
  // two slots held back for words still in the front stages
  assign full_o    = (cnt_q >= icr_pkg::QCntW'(icr_pkg::QDepth - 2));
  assign rd_item_o = mem_q[rptr_q];
  assign do_rd     = rd_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i)  wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + icr_pkg::QCntW'(wr_i) - icr_pkg::QCntW'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

endmodule

// File: hdl/icr_back.sv
module icr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  icr_pkg::icr_item_t q_item_i,
  output logic               q_pop_o,
  input  logic               res_pop_i,
  output logic               res_empty_o,
  output icr_pkg::icr_res_t  res_o
);

  localparam int Ns = icr_pkg::DivSteps;

  typedef struct packed {
    logic signed [31:0]              rvx;
    logic signed [31:0]              rvy;
    logic signed [31:0]              ovx;
    logic signed [31:0]              ovy;
    logic signed [15:0]              nx;
    logic signed [15:0]              ny;
    logic                            applied;
    logic                            sat;
    logic                            mr_zero;
    logic                            mo_zero;
    logic [icr_pkg::DeltaW-1:0]      delta;
  } pay_t;

  function automatic logic ovf(input logic signed [41:0] v);
    ovf = (v > 42'sh0_7FFF_FFFF) || (v < -42'sh0_8000_0000);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [41:0] v);
    if (v > 42'sh0_7FFF_FFFF)       clamp32 = 32'sh7FFF_FFFF;
    else if (v < -42'sh0_8000_0000) clamp32 = -32'sh8000_0000;
    else                            clamp32 = v[31:0];
  endfunction

  logic en;

  // stage 0
  logic               s0_vld_q;
  icr_pkg::icr_item_t s0_item_q;

  // divider stages, index 0 also carries the delta product
  logic        d_vld_q [Ns+1];
  logic [32:0] d_rem_q [Ns+1];
  logic [24:0] d_nb_q  [Ns+1];
  logic [24:0] d_quo_q [Ns+1];
  logic [32:0] d_den_q [Ns+1];
  pay_t        d_pay_q [Ns+1];
  logic [51:0] d_prod_q;

  logic [32:0] rem_d [Ns+1];
  logic [24:0] nb_d  [Ns+1];
  logic [24:0] quo_d [Ns+1];
  pay_t        pay_d [Ns+1];
  logic [33:0] rem2;
  logic        ge;
  logic [51:0] dsum;

  logic [48:0] s16_sum;
  logic [32:0] den0;
  logic [56:0] num0;
  pay_t        pay0;

  // share multipliers
  logic        m1_vld_q, m2_vld_q, m3_vld_q;
  pay_t        m1_pay_q, m2_pay_q, m3_pay_q;
  logic [24:0] wr, wo;
  logic [44:0] m1_rl_q, m1_ol_q;
  logic [41:0] m1_rh_q, m1_oh_q;
  logic [61:0] fr, fo;
  logic [37:0] m2_ar_q, m2_ao_q;
  logic [15:0] m2_mx_q, m2_my_q;
  logic [53:0] m3_prx_q, m3_pry_q, m3_pox_q, m3_poy_q;

  logic [39:0]        crx, cry, cox, coy;
  logic signed [41:0] vrx, vry, vox, voy;
  icr_pkg::icr_res_t  out_res;

  // result buffer
  icr_pkg::icr_res_t out_mem_q [2];
  logic              out_wptr_q, out_rptr_q;
  logic [1:0]        out_cnt_q;
  logic              out_wr, out_rd;

  assign en      = (out_cnt_q != 2'd2);
  assign q_pop_o = en && !q_empty_i;

  always_comb begin
    s16_sum = s0_item_q.sep_mag + 49'd8192;
    den0    = 33'(s0_item_q.ref_mass) + 33'(s0_item_q.oth_mass);
    num0    = {1'b0, s0_item_q.oth_mass, 24'd0} + 57'(den0[32:1]);
    pay0.rvx     = s0_item_q.ref_vel_x;
    pay0.rvy     = s0_item_q.ref_vel_y;
    pay0.ovx     = s0_item_q.oth_vel_x;
    pay0.ovy     = s0_item_q.oth_vel_y;
    pay0.nx      = s0_item_q.normal_x;
    pay0.ny      = s0_item_q.normal_y;
    pay0.applied = s0_item_q.applied;
    pay0.sat     = s0_item_q.sat;
    pay0.mr_zero = (s0_item_q.ref_mass == '0);
    pay0.mo_zero = (s0_item_q.oth_mass == '0);
    pay0.delta   = '0;
  end

  always_comb begin
    dsum = d_prod_q + 52'd16384;
    rem2 = '0;
    ge   = 1'b0;
    rem_d[0] = '0;
    nb_d[0]  = '0;
    quo_d[0] = '0;
    pay_d[0] = '0;
    for (int j = 1; j <= Ns; j++) begin
      rem2     = {d_rem_q[j-1], d_nb_q[j-1][24]};
      ge       = (rem2 >= {1'b0, d_den_q[j-1]});
      rem_d[j] = ge ? 33'(rem2 - {1'b0, d_den_q[j-1]}) : rem2[32:0];
      nb_d[j]  = {d_nb_q[j-1][23:0], 1'b0};
      quo_d[j] = {d_quo_q[j-1][23:0], ge};
      pay_d[j] = d_pay_q[j-1];
      if (j == 1) begin
        pay_d[j].delta = dsum[51:15];
      end
    end
  end

  always_comb begin
    if (d_pay_q[Ns].mr_zero)      wr = '0;
    else if (d_pay_q[Ns].mo_zero) wr = icr_pkg::WOne;
    else                          wr = d_quo_q[Ns];
    wo = icr_pkg::WOne - wr;
    fr = {m1_rh_q, 20'd0} + 62'(m1_rl_q) + 62'h80_0000;
    fo = {m1_oh_q, 20'd0} + 62'(m1_ol_q) + 62'h80_0000;
  end

  always_comb begin
    crx = 40'((m3_prx_q + 54'd8192) >> 14);
    cry = 40'((m3_pry_q + 54'd8192) >> 14);
    cox = 40'((m3_pox_q + 54'd8192) >> 14);
    coy = 40'((m3_poy_q + 54'd8192) >> 14);
    vrx = m3_pay_q.nx[15] ? 42'(m3_pay_q.rvx) - $signed({2'b0, crx})
                          : 42'(m3_pay_q.rvx) + $signed({2'b0, crx});
    vry = m3_pay_q.ny[15] ? 42'(m3_pay_q.rvy) - $signed({2'b0, cry})
                          : 42'(m3_pay_q.rvy) + $signed({2'b0, cry});
    vox = m3_pay_q.nx[15] ? 42'(m3_pay_q.ovx) + $signed({2'b0, cox})
                          : 42'(m3_pay_q.ovx) - $signed({2'b0, cox});
    voy = m3_pay_q.ny[15] ? 42'(m3_pay_q.ovy) + $signed({2'b0, coy})
                          : 42'(m3_pay_q.ovy) - $signed({2'b0, coy});
    if (m3_pay_q.applied) begin
      out_res.ref_new_vel_x   = clamp32(vrx);
      out_res.ref_new_vel_y   = clamp32(vry);
      out_res.oth_new_vel_x   = clamp32(vox);
      out_res.oth_new_vel_y   = clamp32(voy);
      out_res.impulse_applied = 1'b1;
      out_res.saturated       = m3_pay_q.sat || ovf(vrx) || ovf(vry) ||
                                ovf(vox) || ovf(voy);
    end else begin
      out_res.ref_new_vel_x   = m3_pay_q.rvx;
      out_res.ref_new_vel_y   = m3_pay_q.rvy;
      out_res.oth_new_vel_x   = m3_pay_q.ovx;
      out_res.oth_new_vel_y   = m3_pay_q.ovy;
      out_res.impulse_applied = 1'b0;
      out_res.saturated       = 1'b0;
    end
  end

  assign out_wr      = en && m3_vld_q;
  assign out_rd      = res_pop_i && (out_cnt_q != 2'd0);
  assign res_empty_o = (out_cnt_q == 2'd0);
  assign res_o       = out_mem_q[out_rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q   <= 1'b0;
      for (int j = 0; j <= Ns; j++) d_vld_q[j] <= 1'b0;
      m1_vld_q   <= 1'b0;
      m2_vld_q   <= 1'b0;
      m3_vld_q   <= 1'b0;
      out_wptr_q <= 1'b0;
      out_rptr_q <= 1'b0;
      out_cnt_q  <= 2'd0;
    end else begin
      if (en) begin
        s0_vld_q   <= !q_empty_i;
        d_vld_q[0] <= s0_vld_q;
        for (int j = 1; j <= Ns; j++) d_vld_q[j] <= d_vld_q[j-1];
        m1_vld_q   <= d_vld_q[Ns];
        m2_vld_q   <= m1_vld_q;
        m3_vld_q   <= m2_vld_q;
      end
      if (out_wr) out_wptr_q <= !out_wptr_q;
      if (out_rd) out_rptr_q <= !out_rptr_q;
      out_cnt_q <= out_cnt_q + 2'(out_wr) - 2'(out_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_item_q  <= q_item_i;
      d_prod_q   <= 52'(s16_sum[48:14]) * 52'(s0_item_q.f15);
      d_rem_q[0] <= {1'b0, num0[56:25]};
      d_nb_q[0]  <= num0[24:0];
      d_quo_q[0] <= '0;
      d_den_q[0] <= den0;
      d_pay_q[0] <= pay0;
      for (int j = 1; j <= Ns; j++) begin
        d_rem_q[j] <= rem_d[j];
        d_nb_q[j]  <= nb_d[j];
        d_quo_q[j] <= quo_d[j];
        d_den_q[j] <= d_den_q[j-1];
        d_pay_q[j] <= pay_d[j];
      end
      m1_pay_q <= d_pay_q[Ns];
      m1_rl_q  <= 45'(d_pay_q[Ns].delta[19:0]) * 45'(wr);
      m1_rh_q  <= 42'(d_pay_q[Ns].delta[36:20]) * 42'(wr);
      m1_ol_q  <= 45'(d_pay_q[Ns].delta[19:0]) * 45'(wo);
      m1_oh_q  <= 42'(d_pay_q[Ns].delta[36:20]) * 42'(wo);
      m2_pay_q <= m1_pay_q;
      m2_ar_q  <= fr[61:24];
      m2_ao_q  <= fo[61:24];
      m2_mx_q  <= m1_pay_q.nx[15] ? 16'(-m1_pay_q.nx) : 16'(m1_pay_q.nx);
      m2_my_q  <= m1_pay_q.ny[15] ? 16'(-m1_pay_q.ny) : 16'(m1_pay_q.ny);
      m3_pay_q <= m2_pay_q;
      m3_prx_q <= 54'(m2_ar_q) * 54'(m2_mx_q);
      m3_pry_q <= 54'(m2_ar_q) * 54'(m2_my_q);
      m3_pox_q <= 54'(m2_ao_q) * 54'(m2_mx_q);
      m3_poy_q <= 54'(m2_ao_q) * 54'(m2_my_q);
    end
    if (out_wr) begin
      out_mem_q[out_wptr_q] <= out_res;
    end
  end

`ifndef SYNTHESIS
  a_out_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q != 2'd3) else $error("result buffer count out of range");

  a_pass_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wr && !out_res.impulse_applied |->
      !out_res.saturated && (out_res.ref_new_vel_x == m3_pay_q.rvx) &&
      (out_res.oth_new_vel_y == m3_pay_q.ovy))
    else $error("pass-through word altered");

  a_share_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q[Ns] && d_pay_q[Ns].applied |-> wr <= icr_pkg::WOne)
    else $error("mass share above one");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && m3_vld_q |=> m3_vld_q) else $error("last stage lost during stall");
`endif

endmodule

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] rvx, rvy, ovx, ovy;
    logic signed [15:0] nx, ny;
    logic [31:0] mr, mo;
    logic [15:0] hr, er, ho, eo;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [31:0] ref_vel_x_i = '0, ref_vel_y_i = '0, oth_vel_x_i = '0, oth_vel_y_i = '0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0;
  logic [31:0] ref_mass_i = '0, oth_mass_i = '0;
  logic [15:0] ref_hardness_i = '0, ref_elasticity_i = '0;
  logic [15:0] oth_hardness_i = '0, oth_elasticity_i = '0;
  logic signed [31:0] ref_new_vel_x_o, ref_new_vel_y_o, oth_new_vel_x_o, oth_new_vel_y_o;
  logic impulse_applied_o, saturated_o;

  icr_pkg::icr_res_t expected_q[$];
  int mismatches = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int sink_hold = 0;

  impulse_collision_response i_dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [15:0] clamp_coef(input logic [15:0] v, inout bit sat);
    if (v > icr_pkg::CoefOne) begin
      sat = 1'b1;
      return icr_pkg::CoefOne;
    end
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic longint axis_delta(input logic [63:0] a, input logic signed [15:0] n);
    logic [63:0] mag, c;
    mag = (n < 0) ? -longint'(n) : longint'(n);
    c = (a * mag + 64'd8192) >> 14;
    return (n < 0) ? -longint'(c) : longint'(c);
  endfunction

  function automatic icr_pkg::icr_res_t resolve_contact(input contact_t c);
    icr_pkg::icr_res_t r;
    longint sep;
    bit sat;
    logic [63:0] hr, er, ho, eo, rest, f15, s16, delta, wr, wo, ar, ao, den;
    sat = 1'b0;
    r.ref_new_vel_x = c.rvx;
    r.ref_new_vel_y = c.rvy;
    r.oth_new_vel_x = c.ovx;
    r.oth_new_vel_y = c.ovy;
    r.impulse_applied = 1'b0;
    sep = (longint'(c.rvx) - longint'(c.ovx)) * longint'(c.nx)
        + (longint'(c.rvy) - longint'(c.ovy)) * longint'(c.ny);
    if ((c.nx != 0 || c.ny != 0) && sep <= 0 && (c.mr != 0 || c.mo != 0)) begin
      hr = clamp_coef(c.hr, sat);
      er = clamp_coef(c.er, sat);
      ho = clamp_coef(c.ho, sat);
      eo = clamp_coef(c.eo, sat);
      rest = hr * eo + er * ho;
      f15 = ((64'd1 << 30) + rest + 64'd16384) >> 15;
      s16 = (64'(-sep) + 64'd8192) >> 14;
      delta = (s16 * f15 + 64'd16384) >> 15;
      if (c.mr == 0) wr = 0;
      else if (c.mo == 0) wr = 64'd1 << 24;
      else begin
        den = 64'(c.mr) + 64'(c.mo);
        wr = ((64'(c.mo) << 24) + den / 2) / den;
      end
      wo = (64'd1 << 24) - wr;
      ar = (delta * wr + 64'd8388608) >> 24;
      ao = (delta * wo + 64'd8388608) >> 24;
      r.ref_new_vel_x = sat32(longint'(c.rvx) + axis_delta(ar, c.nx), sat);
      r.ref_new_vel_y = sat32(longint'(c.rvy) + axis_delta(ar, c.ny), sat);
      r.oth_new_vel_x = sat32(longint'(c.ovx) - axis_delta(ao, c.nx), sat);
      r.oth_new_vel_y = sat32(longint'(c.ovy) - axis_delta(ao, c.ny), sat);
      r.impulse_applied = 1'b1;
    end
    r.saturated = sat;
    return r;
  endfunction

  task automatic send_contact(input contact_t c);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    push <= 1'b1;
    ref_vel_x_i <= c.rvx;
    ref_vel_y_i <= c.rvy;
    oth_vel_x_i <= c.ovx;
    oth_vel_y_i <= c.ovy;
    normal_x_i <= c.nx;
    normal_y_i <= c.ny;
    ref_mass_i <= c.mr;
    oth_mass_i <= c.mo;
    ref_hardness_i <= c.hr;
    ref_elasticity_i <= c.er;
    oth_hardness_i <= c.ho;
    oth_elasticity_i <= c.eo;
    do @(posedge clk_i); while (full);
    expected_q.push_back(resolve_contact(c));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 200000)) - 100000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 9999)
                                     : 32'h80000000 + $urandom_range(0, 9999);
      default: return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
    endcase
  endfunction

  function automatic logic [15:0] rand_normal();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 16'h0000;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return $urandom;
      default: return $urandom_range(1, 1 << 20);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    c.rvx = rand_vel(); c.rvy = rand_vel(); c.ovx = rand_vel(); c.ovy = rand_vel();
    c.nx = rand_normal(); c.ny = rand_normal();
    c.mr = rand_mass(); c.mo = rand_mass();
    c.hr = rand_coef(); c.er = rand_coef(); c.ho = rand_coef(); c.eo = rand_coef();
    return c;
  endfunction

  function automatic contact_t head_on(input logic signed [31:0] v, input logic [31:0] mr,
                                       input logic [31:0] mo);
    contact_t c;
    c = '{rvx: v, rvy: 0, ovx: -v, ovy: 0, nx: -16'sd16384, ny: 0, mr: mr, mo: mo,
          hr: 16'h4000, er: 16'h4000, ho: 16'h4000, eo: 16'h4000};
    return c;
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_special_cases();
    contact_t c;
    c = head_on(32'sh10000, 32'h100, 32'h100); send_contact(c);
    c.nx = 0; send_contact(c);
    c = head_on(-32'sh10000, 32'h100, 32'h100); send_contact(c);
    c = head_on(32'sh10000, 0, 0); send_contact(c);
    c = head_on(32'sh10000, 0, 32'h100); send_contact(c);
    c = head_on(32'sh10000, 32'h100, 0); send_contact(c);
    c = head_on(32'sh10000, 32'hffffffff, 32'hffffffff); send_contact(c);
    c = head_on(32'sh10000, 32'h1, 32'hffffffff); send_contact(c);
    c.hr = 16'hffff; c.er = 16'h8001; c.ho = 16'h8000; c.eo = 16'h8000; send_contact(c);
    c = head_on(32'sh7fffffff, 32'h100, 32'h100); c.hr = 16'h8000; c.eo = 16'h8000;
    send_contact(c);
    c = head_on(32'sh80000000, 32'h100, 32'h100); send_contact(c);
    c = head_on(32'sh40000000, 32'h100, 32'h100); c.nx = 16'sh8000; c.ny = 16'sh8000;
    c.ovy = 32'sh80000000; send_contact(c);
    c.nx = 16'sh7fff; c.ny = 16'sh7fff; c.rvx = 32'sh80000000; c.rvy = 32'sh80000000;
    c.ovx = 32'sh7fffffff; c.ovy = 32'sh7fffffff; send_contact(c);
    c = head_on(0, 32'h100, 32'h100); send_contact(c);
    c = head_on(32'sh10000, 32'h100, 32'h100); c.hr = 0; c.er = 0; c.ho = 0; c.eo = 0;
    send_contact(c);
    c.hr = 16'hffff; c.er = 16'hffff; c.ho = 16'hffff; c.eo = 16'hffff; send_contact(c);
    wait_drained();
  endtask

  task automatic test_random_stream(input int n);
    repeat (n) send_contact(rand_contact());
  endtask

  task automatic test_backpressure();
    sink_hold = 150;
    repeat (60) send_contact(rand_contact());
    wait_drained();
  endtask

  task automatic test_full_rate();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (150) send_contact(rand_contact());
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_special_cases();
    test_random_stream(300);
    test_backpressure();
    test_random_stream(240);
    test_full_rate();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side: pop control at the falling edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        pop <= 1'b0;
        repeat (sink_hold) @(negedge clk_i);
        sink_hold = 0;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    icr_pkg::icr_res_t exp_w;
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        exp_w = expected_q.pop_front();
        if (exp_w.ref_new_vel_x !== ref_new_vel_x_o || exp_w.ref_new_vel_y !== ref_new_vel_y_o
            || exp_w.oth_new_vel_x !== oth_new_vel_x_o
            || exp_w.oth_new_vel_y !== oth_new_vel_y_o
            || exp_w.impulse_applied !== impulse_applied_o
            || exp_w.saturated !== saturated_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %h %b %b got %h %h %h %h %b %b",
                     exp_w.ref_new_vel_x, exp_w.ref_new_vel_y, exp_w.oth_new_vel_x,
                     exp_w.oth_new_vel_y, exp_w.impulse_applied, exp_w.saturated,
                     ref_new_vel_x_o, ref_new_vel_y_o, oth_new_vel_x_o, oth_new_vel_y_o,
                     impulse_applied_o, saturated_o);
        end
      end
    end
  end

endmodule
